>>> hdl/itfp_pkg.sv
// Shared types, constants and helpers for the idle-tiered frame pacer.
package itfp_pkg;

   // default timestamp width used inside the pacer
   localparam int TIME_WIDTH_DEF = 48;

   localparam int NOW_WIDTH    = 48;
   localparam int PERIOD_WIDTH = 32;
   localparam int THRESH_WIDTH = 40;
   localparam int COUNT_WIDTH  = 32;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH = 40;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ACTIVE_PERIOD    = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IDLE_PERIOD      = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DEEP_IDLE_PERIOD = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAX_DELTA        = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_IDLE_THRESH      = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DEEP_IDLE_THRESH = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SLEEP_THRESH     = 3'd6;

   // register reset values
   localparam logic [PERIOD_WIDTH-1:0] RST_ACTIVE_PERIOD    = 32'd16667;
   localparam logic [PERIOD_WIDTH-1:0] RST_IDLE_PERIOD      = 32'd100000;
   localparam logic [PERIOD_WIDTH-1:0] RST_DEEP_IDLE_PERIOD = 32'd1000000;
   localparam logic [PERIOD_WIDTH-1:0] RST_MAX_DELTA        = 32'd100000;
   localparam logic [THRESH_WIDTH-1:0] RST_IDLE_THRESH      = 40'd5000000;
   localparam logic [THRESH_WIDTH-1:0] RST_DEEP_IDLE_THRESH = 40'd30000000;
   localparam logic [THRESH_WIDTH-1:0] RST_SLEEP_THRESH     = 40'd120000000;

   typedef enum logic [1:0] {
      PS_ACTIVE = 2'd0,
      PS_IDLE   = 2'd1,
      PS_DEEP   = 2'd2,
      PS_SLEEP  = 2'd3
   } pstate_type;

   typedef struct packed {
      logic [PERIOD_WIDTH-1:0] active_period;
      logic [PERIOD_WIDTH-1:0] idle_period;
      logic [PERIOD_WIDTH-1:0] deep_idle_period;
      logic [PERIOD_WIDTH-1:0] max_delta;
      logic [THRESH_WIDTH-1:0] idle_thresh;
      logic [THRESH_WIDTH-1:0] deep_idle_thresh;
      logic [THRESH_WIDTH-1:0] sleep_thresh;
   } cfg_type;

   typedef struct packed {
      logic                 mode;
      logic [NOW_WIDTH-1:0] now_time;
      logic                 animating;
   } item_type;

   typedef struct packed {
      pstate_type              power_state;
      logic                    frame_due;
      logic [PERIOD_WIDTH-1:0] frame_delta;
      logic [PERIOD_WIDTH-1:0] frame_period;
      logic [COUNT_WIDTH-1:0]  transitions_seen;
      logic [COUNT_WIDTH-1:0]  wakeups_seen;
   } result_type;

   // frame period of a power state, zero while sleeping
   function automatic logic [PERIOD_WIDTH-1:0] period_of(cfg_type cfg, pstate_type st);
      logic [PERIOD_WIDTH-1:0] p;
      case (st)
         PS_ACTIVE: p = cfg.active_period;
         PS_IDLE:   p = cfg.idle_period;
         PS_DEEP:   p = cfg.deep_idle_period;
         default:   p = '0;
      endcase
      return p;
   endfunction

endpackage

>>> hdl/itfp_ifs.sv
// Valid/ready channel interfaces for request, response and csr words.
interface itfp_req_if;
   logic                           valid;
   logic                           ready;
   logic                           mode;
   logic [itfp_pkg::NOW_WIDTH-1:0] now_time;
   logic                           animating;

   modport source (output valid, output mode, output now_time, output animating, input ready);
   modport sink   (input valid, input mode, input now_time, input animating, output ready);
endinterface

interface itfp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        power_state;
   logic                              frame_due;
   logic [itfp_pkg::PERIOD_WIDTH-1:0] frame_delta;
   logic [itfp_pkg::PERIOD_WIDTH-1:0] frame_period;
   logic [itfp_pkg::COUNT_WIDTH-1:0]  transitions_seen;
   logic [itfp_pkg::COUNT_WIDTH-1:0]  wakeups_seen;

   modport source (output valid, output power_state, output frame_due, output frame_delta,
                   output frame_period, output transitions_seen, output wakeups_seen,
                   input ready);
   modport sink   (input valid, input power_state, input frame_due, input frame_delta,
                   input frame_period, input transitions_seen, input wakeups_seen,
                   output ready);
endinterface

interface itfp_csr_if;
   logic                                valid;
   logic                                ready;
   logic [itfp_pkg::CSR_IDX_WIDTH-1:0]  index;
   logic [itfp_pkg::CSR_DATA_WIDTH-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/itfp_csr.sv
// Configuration register file of the frame pacer.
module itfp_csr (
   input  logic              clock,
   input  logic              reset,
   itfp_csr_if.sink          csr_bus,
   output itfp_pkg::cfg_type cfg
);

   itfp_pkg::cfg_type cfg_ff;
   logic              wr_en;

   // writes are always taken
   assign csr_bus.ready = 1'b1;
   assign wr_en         = csr_bus.valid;
   assign cfg           = cfg_ff;

   // register write, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_period    <= itfp_pkg::RST_ACTIVE_PERIOD;
         cfg_ff.idle_period      <= itfp_pkg::RST_IDLE_PERIOD;
         cfg_ff.deep_idle_period <= itfp_pkg::RST_DEEP_IDLE_PERIOD;
         cfg_ff.max_delta        <= itfp_pkg::RST_MAX_DELTA;
         cfg_ff.idle_thresh      <= itfp_pkg::RST_IDLE_THRESH;
         cfg_ff.deep_idle_thresh <= itfp_pkg::RST_DEEP_IDLE_THRESH;
         cfg_ff.sleep_thresh     <= itfp_pkg::RST_SLEEP_THRESH;
      end else if (wr_en) begin
         case (csr_bus.index)
            itfp_pkg::CSR_ACTIVE_PERIOD: begin
               cfg_ff.active_period <= csr_bus.data[itfp_pkg::PERIOD_WIDTH-1:0];
            end
            itfp_pkg::CSR_IDLE_PERIOD: begin
               cfg_ff.idle_period <= csr_bus.data[itfp_pkg::PERIOD_WIDTH-1:0];
            end
            itfp_pkg::CSR_DEEP_IDLE_PERIOD: begin
               cfg_ff.deep_idle_period <= csr_bus.data[itfp_pkg::PERIOD_WIDTH-1:0];
            end
            itfp_pkg::CSR_MAX_DELTA: begin
               cfg_ff.max_delta <= csr_bus.data[itfp_pkg::PERIOD_WIDTH-1:0];
            end
            itfp_pkg::CSR_IDLE_THRESH: begin
               cfg_ff.idle_thresh <= csr_bus.data[itfp_pkg::THRESH_WIDTH-1:0];
            end
            itfp_pkg::CSR_DEEP_IDLE_THRESH: begin
               cfg_ff.deep_idle_thresh <= csr_bus.data[itfp_pkg::THRESH_WIDTH-1:0];
            end
            itfp_pkg::CSR_SLEEP_THRESH: begin
               cfg_ff.sleep_thresh <= csr_bus.data[itfp_pkg::THRESH_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

>>> hdl/itfp_core.sv
// Pacer state registers and the single-pass next-state / result logic.
module itfp_core #(
   parameter int TIME_WIDTH = itfp_pkg::TIME_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  itfp_pkg::cfg_type    cfg,
   input  logic                 fire,
   input  itfp_pkg::item_type   item,
   output itfp_pkg::result_type result
);

   localparam int TW = TIME_WIDTH;
   localparam int CW = (TW > itfp_pkg::THRESH_WIDTH) ? TW : itfp_pkg::THRESH_WIDTH;
   localparam int CNTW = itfp_pkg::COUNT_WIDTH;
   localparam int PW = itfp_pkg::PERIOD_WIDTH;

   logic                started_ff;
   itfp_pkg::pstate_type state_ff, state_in;
   logic [TW-1:0]       act_ff, act_in;
   logic [TW-1:0]       lframe_ff, lframe_in;
   logic [TW-1:0]       nframe_ff, nframe_in;
   logic                zero_ff, zero_in;
   logic [CNTW-1:0]     trans_ff, trans_in;
   logic [CNTW-1:0]     wake_ff, wake_in;

   // state as seen by this word, after the start-up load
   itfp_pkg::pstate_type st0;
   logic [TW-1:0]       act0, lframe0, nframe0;
   logic                zero0;
   logic [CNTW-1:0]     trans0, wake0;

   logic [63:0]         now_ext;
   logic [TW-1:0]       now_raw, now_c1, now_c;
   logic [TW-1:0]       elapsed, diff;
   logic [CW-1:0]       el_ext;
   itfp_pkg::pstate_type want;
   logic                is_wake;
   logic [TW-1:0]       t_wake;
   logic                due;
   logic [PW-1:0]       delta, per;
   logic [TW:0]         sum;

   always_comb begin
      // timestamp reduced to the working width
      now_ext = 64'(item.now_time);
      now_raw = now_ext[TW-1:0];

      // first word after reset starts the timeline
      if (!started_ff) begin
         st0     = itfp_pkg::PS_ACTIVE;
         act0    = now_raw;
         lframe0 = now_raw;
         nframe0 = now_raw;
         zero0   = 1'b1;
         trans0  = '0;
         wake0   = '0;
      end else begin
         st0     = state_ff;
         act0    = act_ff;
         lframe0 = lframe_ff;
         nframe0 = nframe_ff;
         zero0   = zero_ff;
         trans0  = trans_ff;
         wake0   = wake_ff;
      end

      // ticks never go backwards
      now_c1 = (now_raw < lframe0) ? lframe0 : now_raw;
      now_c  = (now_c1 < act0) ? act0 : now_c1;

      // idle tier from inactivity, sleep tested first
      elapsed = now_c - act0;
      el_ext  = CW'(elapsed);
      if (el_ext >= CW'(cfg.sleep_thresh)) begin
         want = itfp_pkg::PS_SLEEP;
      end else if (el_ext >= CW'(cfg.deep_idle_thresh)) begin
         want = itfp_pkg::PS_DEEP;
      end else if (el_ext >= CW'(cfg.idle_thresh)) begin
         want = itfp_pkg::PS_IDLE;
      end else begin
         want = itfp_pkg::PS_ACTIVE;
      end

      is_wake = item.mode || (item.animating && (st0 != itfp_pkg::PS_ACTIVE));
      t_wake  = item.mode ? now_raw : now_c;

      state_in  = st0;
      act_in    = act0;
      lframe_in = lframe0;
      nframe_in = nframe0;
      zero_in   = zero0;
      trans_in  = trans0;
      wake_in   = wake0;
      due       = 1'b0;
      delta     = '0;
      per       = '0;
      sum       = '0;
      diff      = '0;

      if (!item.mode && item.animating) begin
         act_in = now_c;
      end

      // wake: back to active, restart frame timing
      if (is_wake) begin
         wake_in = wake0 + 1'b1;
         act_in  = t_wake;
         if (st0 != itfp_pkg::PS_ACTIVE) begin
            state_in = itfp_pkg::PS_ACTIVE;
            trans_in = trans0 + 1'b1;
         end
         lframe_in = t_wake;
         nframe_in = t_wake;
         zero_in   = 1'b1;
      end else if (!item.mode && !item.animating && (want != st0)) begin
         state_in = want;
         trans_in = trans0 + 1'b1;
         if (want != itfp_pkg::PS_SLEEP) begin
            nframe_in = now_c;
         end
      end

      // frame due on a tick
      if (!item.mode && (state_in != itfp_pkg::PS_SLEEP) && (now_c >= nframe_in)) begin
         due = 1'b1;
         per = itfp_pkg::period_of(cfg, state_in);
         if (zero_in) begin
            zero_in = 1'b0;
         end else begin
            diff  = now_c - lframe_in;
            delta = (diff > TW'(cfg.max_delta)) ? cfg.max_delta : diff[PW-1:0];
         end
         lframe_in = now_c;
         // saturate next frame time at the top of the range
         sum       = {1'b0, now_c} + (TW+1)'(per);
         nframe_in = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
      end

      result.power_state      = state_in;
      result.frame_due        = due;
      result.frame_delta      = delta;
      result.frame_period     = itfp_pkg::period_of(cfg, state_in);
      result.transitions_seen = trans_in;
      result.wakeups_seen     = wake_in;
   end

   // state update once per word
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         state_ff   <= itfp_pkg::PS_ACTIVE;
         act_ff     <= '0;
         lframe_ff  <= '0;
         nframe_ff  <= '0;
         zero_ff    <= 1'b1;
         trans_ff   <= '0;
         wake_ff    <= '0;
      end else if (fire) begin
         started_ff <= 1'b1;
         state_ff   <= state_in;
         act_ff     <= act_in;
         lframe_ff  <= lframe_in;
         nframe_ff  <= nframe_in;
         zero_ff    <= zero_in;
         trans_ff   <= trans_in;
         wake_ff    <= wake_in;
      end
   end

endmodule

>>> hdl/idle_tiered_frame_pacer.sv
// Idle-tiered frame pacer: input register, state update stage, response register.
// A word accepted into the input register moves to the response register unless rsp stalls.
// Throughput: one word per cycle unless rsp stalls, limited by the single state-update stage.
// Backpressure on the response side stalls the input register; no word is lost.
// Reset (synchronous, active high) empties both registers, loads register
// defaults and returns the pacer to its not-started state.
module idle_tiered_frame_pacer #(
   parameter int TIME_WIDTH = itfp_pkg::TIME_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   itfp_req_if.sink   req_bus,
   itfp_rsp_if.source rsp_bus,
   itfp_csr_if.sink   csr_bus
);

   itfp_pkg::cfg_type    cfg;
   itfp_pkg::item_type   item_ff, item_in;
   logic                 item_vld_ff;
   itfp_pkg::result_type core_res;
   itfp_pkg::result_type out_ff;
   logic                 out_vld_ff;
   logic                 advance;
   logic                 req_take;

   itfp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   itfp_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (advance),
      .item   (item_ff),
      .result (core_res)
   );

   // handshake
   assign advance       = item_vld_ff && (!out_vld_ff || rsp_bus.ready);
   assign req_bus.ready = !item_vld_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   assign item_in.mode      = req_bus.mode;
   assign item_in.now_time  = req_bus.now_time;
   assign item_in.animating = req_bus.animating;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else if (req_bus.ready) begin
         item_vld_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= core_res;
      end
   end

   assign rsp_bus.valid            = out_vld_ff;
   assign rsp_bus.power_state      = out_ff.power_state;
   assign rsp_bus.frame_due        = out_ff.frame_due;
   assign rsp_bus.frame_delta      = out_ff.frame_delta;
   assign rsp_bus.frame_period     = out_ff.frame_period;
   assign rsp_bus.transitions_seen = out_ff.transitions_seen;
   assign rsp_bus.wakeups_seen     = out_ff.wakeups_seen;

endmodule

>>> hdl/itfp_checker.sv
// Port-level assertions for the frame pacer and their bind to the top level.
module itfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  power_state,
   input logic        frame_due,
   input logic [31:0] frame_delta,
   input logic [31:0] frame_period
);

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(frame_delta) && $stable(power_state))
      else $error("response word changed while stalled");

   // rsp valid must be high behind each accepted word, past the input and response registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("response missing after accepted request");

   // no delta reported without a frame
   a_delta_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !frame_due |-> frame_delta == 32'd0)
      else $error("nonzero frame delta without frame due");

   // sleep renders nothing and has no period
   a_sleep: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (power_state == itfp_pkg::PS_SLEEP) |-> !frame_due && frame_period == 32'd0)
      else $error("frame activity while sleeping");

endmodule

bind idle_tiered_frame_pacer itfp_checker u_itfp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .power_state  (rsp_bus.power_state),
   .frame_due    (rsp_bus.frame_due),
   .frame_delta  (rsp_bus.frame_delta),
   .frame_period (rsp_bus.frame_period)
);

>>> tb/idle_tiered_frame_pacer_tb.sv
// Self-checking testbench for the idle-tiered frame pacer: directed and random ticks and wakes.
module idle_tiered_frame_pacer_tb;

   localparam int TW = itfp_pkg::TIME_WIDTH_DEF;
   localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_WAKE = 1'b1;
   localparam int DRAIN_CYCLES = 4;
   localparam int LIMIT_CYCLES = 400000;

   typedef enum logic {OP_WORD, OP_CSR} op_kind_type;

   typedef struct {
      op_kind_type                                 kind;
      itfp_pkg::item_type                          word;
      logic [itfp_pkg::CSR_IDX_WIDTH-1:0]          idx;
      logic [itfp_pkg::CSR_DATA_WIDTH-1:0]         data;
   } work_op_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   itfp_req_if req_bus();
   itfp_rsp_if rsp_bus();
   itfp_csr_if csr_bus();

   idle_tiered_frame_pacer uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #2 clock = ~clock;

   // stimulus and scoreboard storage
   work_op_type          work_q[$];
   itfp_pkg::result_type paced_q[$];
   itfp_pkg::result_type seen_rsp, want_rsp;
   int          mismatches = 0;
   int          cycle_count = 0;
   logic        calm = 1'b0;
   logic        req_fire = 1'b0;
   logic        csr_fire = 1'b0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned settle_cnt = 0;

   // generator state
   logic [TW-1:0] cur_t = 48'd1000;
   logic [31:0]   step_max = 32'd64;
   int unsigned   anim_pct = 25;
   int unsigned   quiet_left = 0;

   // pacer model state and settings
   itfp_pkg::cfg_type    m_cfg;
   logic                 m_started;
   itfp_pkg::pstate_type m_state;
   logic [TW-1:0]        m_last_act, m_last_frame, m_next_frame;
   logic                 m_zero_delta;
   logic [31:0]          m_transitions, m_wakeups;

   function automatic logic [31:0] state_period(itfp_pkg::pstate_type st);
      logic [31:0] p;
      case (st)
         itfp_pkg::PS_ACTIVE: p = m_cfg.active_period;
         itfp_pkg::PS_IDLE:   p = m_cfg.idle_period;
         itfp_pkg::PS_DEEP:   p = m_cfg.deep_idle_period;
         default:             p = '0;
      endcase
      return p;
   endfunction

   function automatic void enter_state(itfp_pkg::pstate_type st, logic [TW-1:0] t);
      if (m_state != st) begin
         m_state = st;
         m_transitions = m_transitions + 32'd1;
         // sleep schedules nothing; any other state gets a frame at once
         if (st != itfp_pkg::PS_SLEEP) m_next_frame = t;
      end
   endfunction

   function automatic void wake_at(logic [TW-1:0] t);
      m_wakeups = m_wakeups + 32'd1;
      m_last_act = t;
      enter_state(itfp_pkg::PS_ACTIVE, t);
      m_last_frame = t;
      m_next_frame = t;
      m_zero_delta = 1'b1;
   endfunction

   // advance the pacer model by one word and return the response it yields
   function automatic itfp_pkg::result_type pacer_next(itfp_pkg::item_type w);
      logic [TW-1:0]        t;
      logic [TW-1:0]        el;
      logic [TW-1:0]        per;
      logic [TW-1:0]        dlt;
      logic                 due;
      itfp_pkg::result_type r;
      t = w.now_time;
      due = 1'b0;
      dlt = '0;
      if (!m_started) begin
         m_started = 1'b1;
         m_state = itfp_pkg::PS_ACTIVE;
         m_transitions = '0;
         m_wakeups = '0;
         m_last_act = t;
         m_last_frame = t;
         m_next_frame = t;
         m_zero_delta = 1'b1;
      end
      if (w.mode == MODE_WAKE) begin
         wake_at(t);
      end else begin
         // ticks never move time backwards
         if (t < m_last_frame) t = m_last_frame;
         if (t < m_last_act) t = m_last_act;
         if (w.animating) begin
            m_last_act = t;
            if (m_state != itfp_pkg::PS_ACTIVE) wake_at(t);
         end else begin
            el = t - m_last_act;
            if (el >= m_cfg.sleep_thresh) enter_state(itfp_pkg::PS_SLEEP, t);
            else if (el >= m_cfg.deep_idle_thresh) enter_state(itfp_pkg::PS_DEEP, t);
            else if (el >= m_cfg.idle_thresh) enter_state(itfp_pkg::PS_IDLE, t);
            else enter_state(itfp_pkg::PS_ACTIVE, t);
         end
         if (m_state != itfp_pkg::PS_SLEEP && t >= m_next_frame) begin
            per = TW'(state_period(m_state));
            due = 1'b1;
            if (m_zero_delta) begin
               m_zero_delta = 1'b0;
            end else begin
               dlt = t - m_last_frame;
               if (dlt > m_cfg.max_delta) dlt = TW'(m_cfg.max_delta);
            end
            m_last_frame = t;
            m_next_frame = (per > TIME_MAX - t) ? TIME_MAX : t + per;
         end
      end
      r.power_state      = m_state;
      r.frame_due        = due;
      r.frame_delta      = dlt[31:0];
      r.frame_period     = state_period(m_state);
      r.transitions_seen = m_transitions;
      r.wakeups_seen     = m_wakeups;
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [31:0] rand_period(int unsigned hi);
      int unsigned r;
      logic [31:0] v;
      r = $urandom_range(0, 9);
      if (r == 0) v = 32'd1;
      else if (r == 1) v = '1;
      else if (r == 2) v = $urandom;
      else v = $urandom_range(1, hi);
      if (v == '0) v = 32'd1;
      return v;
   endfunction

   task automatic add_word(logic md, logic [TW-1:0] t, logic an);
      work_op_type op;
      op.kind = OP_WORD;
      op.word.mode = md;
      op.word.now_time = t;
      op.word.animating = an;
      op.idx = '0;
      op.data = '0;
      work_q.push_back(op);
   endtask

   task automatic add_csr(logic [itfp_pkg::CSR_IDX_WIDTH-1:0] idx,
                          logic [itfp_pkg::CSR_DATA_WIDTH-1:0] data);
      work_op_type op;
      op.kind = OP_CSR;
      op.word = '0;
      op.idx = idx;
      op.data = data;
      work_q.push_back(op);
   endtask

   // write all seven registers with a fresh random setting
   task automatic roll_settings();
      logic [63:0] w;
      logic [39:0] ia, da, sa, top;
      int unsigned sel;
      sel = $urandom_range(0, 9);
      add_csr(itfp_pkg::CSR_ACTIVE_PERIOD, {8'h00, rand_period(300)});
      add_csr(itfp_pkg::CSR_IDLE_PERIOD, {8'h00, rand_period(600)});
      add_csr(itfp_pkg::CSR_DEEP_IDLE_PERIOD, {8'h00, rand_period(1500)});
      add_csr(itfp_pkg::CSR_MAX_DELTA, {8'h00, rand_period(500)});
      if (sel == 0) begin
         // thresholds in arbitrary order
         ia = 40'($urandom_range(1, 1500));
         da = 40'($urandom_range(2, 1500));
         sa = 40'($urandom_range(3, 1500));
      end else if (sel == 1) begin
         // full-width thresholds
         w = {$urandom, $urandom};
         ia = (w[39:0] < 40'd1) ? 40'd1 : w[39:0];
         w = {$urandom, $urandom};
         da = (w[39:0] < 40'd2) ? 40'd2 : w[39:0];
         w = {$urandom, $urandom};
         sa = (w[39:0] < 40'd3) ? 40'd3 : w[39:0];
      end else begin
         ia = 40'($urandom_range(1, 400));
         da = ia + 40'($urandom_range(1, 800));
         sa = da + 40'($urandom_range(1, 1500));
      end
      add_csr(itfp_pkg::CSR_IDLE_THRESH, ia);
      add_csr(itfp_pkg::CSR_DEEP_IDLE_THRESH, da);
      add_csr(itfp_pkg::CSR_SLEEP_THRESH, sa);
      top = (ia > da) ? ia : da;
      if (sa > top) top = sa;
      step_max = (top > 40'd100000) ? 32'h00FF_FFFF : top[31:0] / 8 + 32'd2;
      case ($urandom_range(0, 2))
         0: anim_pct = 5;
         1: anim_pct = 25;
         default: anim_pct = 60;
      endcase
   endtask

   task automatic random_words(int n);
      logic [63:0] w;
      logic [TW:0] sum;
      logic [TW-1:0] t;
      logic [31:0] back;
      logic md, an;
      int unsigned r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         md = ($urandom_range(0, 99) < 7) ? MODE_WAKE : MODE_TICK;
         if (r < 75) begin
            sum = {1'b0, cur_t} + (TW+1)'($urandom_range(0, step_max));
            cur_t = sum[TW] ? TIME_MAX : sum[TW-1:0];
            t = cur_t;
         end else if (r < 87) begin
            // stale timestamp
            back = $urandom_range(0, step_max);
            t = (cur_t > back) ? cur_t - back : '0;
         end else if (r < 92) begin
            t = cur_t;
         end else if (r < 96) begin
            w = {$urandom, $urandom};
            cur_t = w[TW-1:0];
            t = cur_t;
         end else begin
            cur_t = TIME_MAX - TW'($urandom_range(0, step_max));
            t = cur_t;
         end
         // quiet runs let the pacer fall through idle, deep idle and sleep
         if (quiet_left > 0) begin
            an = 1'b0;
            quiet_left--;
         end else begin
            an = ($urandom_range(0, 99) < anim_pct);
            if ($urandom_range(0, 11) == 0) quiet_left = $urandom_range(10, 60);
         end
         add_word(md, t, an);
      end
   endtask

   // cycle count, timeout and idle-pattern switching
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
   end

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("Test completed with failures");
      $finish;
   end

   // input and csr driver, fed from work_q
   always @(negedge clock) begin : word_driver
      logic req_on, csr_on;
      work_op_type op;
      if (reset) begin
         req_bus.valid <= 1'b0;
         csr_bus.valid <= 1'b0;
      end else begin
         req_on = req_bus.valid && !req_fire;
         csr_on = csr_bus.valid && !csr_fire;
         if (paced_q.size() == 0 && !req_on && !csr_on) settle_cnt = settle_cnt + 1;
         else settle_cnt = 0;
         if (!req_on && !csr_on) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (work_q.size() > 0) begin
               if (work_q[0].kind == OP_CSR) begin
                  // registers change only once the pacer has drained
                  if (settle_cnt >= DRAIN_CYCLES) begin
                     op = work_q.pop_front();
                     csr_bus.index <= op.idx;
                     csr_bus.data <= op.data;
                     csr_on = 1'b1;
                  end
               end else begin
                  op = work_q.pop_front();
                  req_bus.mode <= op.word.mode;
                  req_bus.now_time <= op.word.now_time;
                  req_bus.animating <= op.word.animating;
                  req_on = 1'b1;
                  gap_left = pick_gap();
               end
            end
         end
         req_bus.valid <= req_on;
         csr_bus.valid <= csr_on;
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!calm && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
   end

   // monitor: register writes, accepted words and responses
   always @(posedge clock) begin
      if (reset) begin
         m_cfg = '{active_period: itfp_pkg::RST_ACTIVE_PERIOD,
                   idle_period: itfp_pkg::RST_IDLE_PERIOD,
                   deep_idle_period: itfp_pkg::RST_DEEP_IDLE_PERIOD,
                   max_delta: itfp_pkg::RST_MAX_DELTA,
                   idle_thresh: itfp_pkg::RST_IDLE_THRESH,
                   deep_idle_thresh: itfp_pkg::RST_DEEP_IDLE_THRESH,
                   sleep_thresh: itfp_pkg::RST_SLEEP_THRESH};
         m_started = 1'b0;
         m_state = itfp_pkg::PS_ACTIVE;
         m_last_act = '0;
         m_last_frame = '0;
         m_next_frame = '0;
         m_zero_delta = 1'b1;
         m_transitions = '0;
         m_wakeups = '0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_rsp.power_state      = itfp_pkg::pstate_type'(rsp_bus.power_state);
            seen_rsp.frame_due        = rsp_bus.frame_due;
            seen_rsp.frame_delta      = rsp_bus.frame_delta;
            seen_rsp.frame_period     = rsp_bus.frame_period;
            seen_rsp.transitions_seen = rsp_bus.transitions_seen;
            seen_rsp.wakeups_seen     = rsp_bus.wakeups_seen;
            if (paced_q.size() == 0) begin
               if (mismatches < 10)
                  $display("cycle %0d: response word with none expected: state %0d due %0d",
                           cycle_count, seen_rsp.power_state, seen_rsp.frame_due);
               mismatches++;
            end else begin
               want_rsp = paced_q.pop_front();
               if (seen_rsp !== want_rsp) begin
                  if (mismatches < 10)
                     $display({"cycle %0d: expected/actual state %0d/%0d due %0d/%0d ",
                               "delta %0d/%0d period %0d/%0d trans %0d/%0d wakes %0d/%0d"},
                              cycle_count, want_rsp.power_state, seen_rsp.power_state,
                              want_rsp.frame_due, seen_rsp.frame_due,
                              want_rsp.frame_delta, seen_rsp.frame_delta,
                              want_rsp.frame_period, seen_rsp.frame_period,
                              want_rsp.transitions_seen, seen_rsp.transitions_seen,
                              want_rsp.wakeups_seen, seen_rsp.wakeups_seen);
                  mismatches++;
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               itfp_pkg::CSR_ACTIVE_PERIOD:    m_cfg.active_period = csr_bus.data[31:0];
               itfp_pkg::CSR_IDLE_PERIOD:      m_cfg.idle_period = csr_bus.data[31:0];
               itfp_pkg::CSR_DEEP_IDLE_PERIOD: m_cfg.deep_idle_period = csr_bus.data[31:0];
               itfp_pkg::CSR_MAX_DELTA:        m_cfg.max_delta = csr_bus.data[31:0];
               itfp_pkg::CSR_IDLE_THRESH:      m_cfg.idle_thresh = csr_bus.data;
               itfp_pkg::CSR_DEEP_IDLE_THRESH: m_cfg.deep_idle_thresh = csr_bus.data;
               itfp_pkg::CSR_SLEEP_THRESH:     m_cfg.sleep_thresh = csr_bus.data;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready)
            paced_q.push_back(pacer_next(itfp_pkg::item_type'{mode: req_bus.mode,
                                                              now_time: req_bus.now_time,
                                                              animating: req_bus.animating}));
      end
      req_fire <= !reset && req_bus.valid && req_bus.ready;
      csr_fire <= !reset && csr_bus.valid && csr_bus.ready;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_TICK;
      req_bus.now_time = '0;
      req_bus.animating = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = itfp_pkg::CSR_ACTIVE_PERIOD;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;

      // default settings: start, clamping, each power state, wake paths, saturation
      add_word(MODE_TICK, 48'd1000, 1'b0);
      add_word(MODE_TICK, 48'd17667, 1'b0);
      add_word(MODE_TICK, 48'd500, 1'b0);
      add_word(MODE_TICK, 48'd200000, 1'b1);
      add_word(MODE_TICK, 48'd5200000, 1'b0);
      add_word(MODE_TICK, 48'd30300000, 1'b0);
      add_word(MODE_TICK, 48'd121000000, 1'b0);
      add_word(MODE_TICK, 48'd121000010, 1'b1);
      add_word(MODE_WAKE, 48'd50, 1'b1);
      add_word(MODE_TICK, 48'hFFFF_FFFF_FF00, 1'b1);
      add_word(MODE_TICK, TIME_MAX, 1'b0);
      add_word(MODE_WAKE, 48'd0, 1'b0);

      // largest settings
      add_csr(itfp_pkg::CSR_ACTIVE_PERIOD, 40'h00_FFFF_FFFF);
      add_csr(itfp_pkg::CSR_IDLE_PERIOD, 40'h00_FFFF_FFFF);
      add_csr(itfp_pkg::CSR_DEEP_IDLE_PERIOD, 40'h00_FFFF_FFFF);
      add_csr(itfp_pkg::CSR_MAX_DELTA, 40'h00_FFFF_FFFF);
      add_csr(itfp_pkg::CSR_IDLE_THRESH, 40'hFF_FFFF_FFFF);
      add_csr(itfp_pkg::CSR_DEEP_IDLE_THRESH, 40'hFF_FFFF_FFFF);
      add_csr(itfp_pkg::CSR_SLEEP_THRESH, 40'hFF_FFFF_FFFF);
      add_word(MODE_WAKE, 48'd1000, 1'b0);
      add_word(MODE_TICK, 48'h2_0000_03E8, 1'b0);
      add_word(MODE_TICK, 48'h4_0000_0000, 1'b0);
      add_word(MODE_TICK, 48'h200_0000_0000, 1'b0);
      add_word(MODE_TICK, TIME_MAX, 1'b1);

      // smallest settings: one tick per state step
      add_csr(itfp_pkg::CSR_ACTIVE_PERIOD, 40'd1);
      add_csr(itfp_pkg::CSR_IDLE_PERIOD, 40'd1);
      add_csr(itfp_pkg::CSR_DEEP_IDLE_PERIOD, 40'd1);
      add_csr(itfp_pkg::CSR_MAX_DELTA, 40'd1);
      add_csr(itfp_pkg::CSR_IDLE_THRESH, 40'd1);
      add_csr(itfp_pkg::CSR_DEEP_IDLE_THRESH, 40'd2);
      add_csr(itfp_pkg::CSR_SLEEP_THRESH, 40'd3);
      add_word(MODE_WAKE, 48'd10, 1'b1);
      add_word(MODE_TICK, 48'd11, 1'b0);
      add_word(MODE_TICK, 48'd12, 1'b0);
      add_word(MODE_TICK, 48'd13, 1'b0);
      add_word(MODE_TICK, 48'd14, 1'b1);

      // thresholds out of order
      add_csr(itfp_pkg::CSR_ACTIVE_PERIOD, 40'd7);
      add_csr(itfp_pkg::CSR_IDLE_PERIOD, 40'd9);
      add_csr(itfp_pkg::CSR_DEEP_IDLE_PERIOD, 40'd11);
      add_csr(itfp_pkg::CSR_MAX_DELTA, 40'd5);
      add_csr(itfp_pkg::CSR_IDLE_THRESH, 40'd300);
      add_csr(itfp_pkg::CSR_DEEP_IDLE_THRESH, 40'd100);
      add_csr(itfp_pkg::CSR_SLEEP_THRESH, 40'd200);
      add_word(MODE_WAKE, 48'd20, 1'b0);
      add_word(MODE_TICK, 48'd130, 1'b0);
      add_word(MODE_TICK, 48'd260, 1'b0);

      // random phases, each under its own settings
      for (int ph = 0; ph < 8; ph++) begin
         roll_settings();
         random_words(110);
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (work_q.size() != 0 || req_bus.valid || csr_bus.valid || paced_q.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatches == 0 && paced_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/itfp_pkg.sv
hdl/itfp_ifs.sv
hdl/itfp_csr.sv
hdl/itfp_core.sv
hdl/idle_tiered_frame_pacer.sv
hdl/itfp_checker.sv
tb/idle_tiered_frame_pacer_tb.sv
